/* rtl/lsdc_pkg.sv */
// ----------------------------------------------------------------------------
// lsdc_pkg: shared types and constants for the lidar scan deframer
// Frame layout constants, sync codes, the quarter-wave offset table and the
// point record that travels between the deframer and the coordinate stages.
// ----------------------------------------------------------------------------
package lsdc_pkg;

   localparam int PACKETS_PER_FRAME = 60;
   localparam int COS_FRAC_BITS     = 16;

   localparam int PKT_W = (PACKETS_PER_FRAME > 1) ? $clog2(PACKETS_PER_FRAME) : 1;
   localparam int QW    = COS_FRAC_BITS + 1;

   localparam logic [7:0] SYNC_BYTE0 = 8'hFA;
   localparam logic [7:0] SYNC_BYTE1 = 8'hA0;

   // packet byte offsets
   localparam logic [5:0] OFF_HDR0     = 6'd0;
   localparam logic [5:0] OFF_HDR1     = 6'd1;
   localparam logic [5:0] OFF_SPEED_LO = 6'd2;
   localparam logic [5:0] OFF_SPEED_HI = 6'd3;
   localparam logic [5:0] OFF_RD_FIRST = 6'd4;
   localparam logic [5:0] OFF_RD_END   = 6'd40;
   localparam logic [5:0] OFF_LAST     = 6'd41;
   localparam logic [5:0] OFF_AFTER_SYNC = 6'd2;

   // byte phase inside a six-byte reading
   localparam logic [2:0] PH_INT_LO   = 3'd0;
   localparam logic [2:0] PH_INT_HI   = 3'd1;
   localparam logic [2:0] PH_RANGE_LO = 3'd2;
   localparam logic [2:0] PH_RANGE_HI = 3'd3;
   localparam logic [2:0] PH_LAST     = 3'd5;
   localparam logic [2:0] RD_LAST     = 3'd5;

   localparam logic [8:0] ANGLE_STEP = 9'd6;

   // floor(v / 10) for 16-bit v as (v * RPM_RECIP) >> RPM_SHIFT
   localparam logic [15:0] RPM_RECIP = 16'd52429;
   localparam int          RPM_SHIFT = 19;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [14:0] CENTER_RESET = 15'd5000;

   typedef enum logic [1:0] {
      SYNC_HUNT,
      SYNC_GOT_FA,
      SYNC_FRAME
   } sync_type;

   typedef struct packed {
      logic        frame_done;
      logic [8:0]  angle;
      logic [15:0] range_mm;
      logic [15:0] intensity;
      logic [12:0] rpm;
      logic [6:0]  dx_idx;
      logic [6:0]  dy_idx;
      logic        x_neg;
      logic        y_neg;
   } lsdc_pt_type;

   typedef logic [90:0][QW-1:0] qtab_type;

   // sin(d degrees) scaled by 1e10
   function automatic longint unsigned sin_e10(input int d);
      longint unsigned v;
      unique case (d)
         0: v = 64'd0;            1: v = 64'd174524064;    2: v = 64'd348994967;
         3: v = 64'd523359562;    4: v = 64'd697564737;    5: v = 64'd871557427;
         6: v = 64'd1045284633;   7: v = 64'd1218693434;   8: v = 64'd1391731010;
         9: v = 64'd1564344650;  10: v = 64'd1736481777;  11: v = 64'd1908089954;
        12: v = 64'd2079116908;  13: v = 64'd2249510543;  14: v = 64'd2419218956;
        15: v = 64'd2588190451;  16: v = 64'd2756373558;  17: v = 64'd2923717047;
        18: v = 64'd3090169944;  19: v = 64'd3255681545;  20: v = 64'd3420201433;
        21: v = 64'd3583679495;  22: v = 64'd3746065934;  23: v = 64'd3907311285;
        24: v = 64'd4067366431;  25: v = 64'd4226182617;  26: v = 64'd4383711468;
        27: v = 64'd4539904997;  28: v = 64'd4694715628;  29: v = 64'd4848096202;
        30: v = 64'd5000000000;  31: v = 64'd5150380749;  32: v = 64'd5299192642;
        33: v = 64'd5446390350;  34: v = 64'd5591929035;  35: v = 64'd5735764364;
        36: v = 64'd5877852523;  37: v = 64'd6018150232;  38: v = 64'd6156614753;
        39: v = 64'd6293203910;  40: v = 64'd6427876097;  41: v = 64'd6560590290;
        42: v = 64'd6691306064;  43: v = 64'd6819983601;  44: v = 64'd6946583705;
        45: v = 64'd7071067812;  46: v = 64'd7193398003;  47: v = 64'd7313537016;
        48: v = 64'd7431448255;  49: v = 64'd7547095802;  50: v = 64'd7660444431;
        51: v = 64'd7771459615;  52: v = 64'd7880107536;  53: v = 64'd7986355100;
        54: v = 64'd8090169944;  55: v = 64'd8191520443;  56: v = 64'd8290375726;
        57: v = 64'd8386705679;  58: v = 64'd8480480962;  59: v = 64'd8571673007;
        60: v = 64'd8660254038;  61: v = 64'd8746197071;  62: v = 64'd8829475929;
        63: v = 64'd8910065242;  64: v = 64'd8987940463;  65: v = 64'd9063077870;
        66: v = 64'd9135454576;  67: v = 64'd9205048535;  68: v = 64'd9271838546;
        69: v = 64'd9335804265;  70: v = 64'd9396926208;  71: v = 64'd9455185756;
        72: v = 64'd9510565163;  73: v = 64'd9563047560;  74: v = 64'd9612616959;
        75: v = 64'd9659258263;  76: v = 64'd9702957263;  77: v = 64'd9743700648;
        78: v = 64'd9781476007;  79: v = 64'd9816271834;  80: v = 64'd9848077530;
        81: v = 64'd9876883406;  82: v = 64'd9902680687;  83: v = 64'd9925461516;
        84: v = 64'd9945218954;  85: v = 64'd9961946981;  86: v = 64'd9975640503;
        87: v = 64'd9986295348;  88: v = 64'd9993908270;  89: v = 64'd9998476952;
        default: v = 64'd10000000000;
      endcase
      return v;
   endfunction

   // quarter-wave table in Q1.COS_FRAC_BITS, truncated
   function automatic qtab_type build_qtab();
      qtab_type        t;
      longint unsigned v;
      for (int d = 0; d <= 90; d++) begin
         v = (sin_e10(d) << COS_FRAC_BITS) / 64'd10000000000;
         t[d] = QW'(v);
      end
      return t;
   endfunction

   localparam qtab_type QTAB = build_qtab();

endpackage

/* rtl/lsdc_req_if.sv */
// ----------------------------------------------------------------------------
// lsdc_req_if: byte channel into the deframer
// One received serial byte per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsdc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/lsdc_rsp_if.sv */
// ----------------------------------------------------------------------------
// lsdc_rsp_if: point channel out of the deframer
// One point or frame-end marker per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsdc_rsp_if;
   logic        valid;
   logic        ready;
   logic        point_valid;
   logic        frame_done;
   logic [8:0]  angle_index;
   logic [15:0] range_mm;
   logic [15:0] intensity;
   logic [16:0] x_pos;
   logic [16:0] y_pos;
   logic [12:0] rpm;

   modport source (output valid, output point_valid, output frame_done,
                   output angle_index, output range_mm, output intensity,
                   output x_pos, output y_pos, output rpm, input ready);
   modport sink   (input valid, input point_valid, input frame_done,
                   input angle_index, input range_mm, input intensity,
                   input x_pos, input y_pos, input rpm, output ready);
endinterface

/* rtl/lsdc_deframer.sv */
// ----------------------------------------------------------------------------
// lsdc_deframer: sync hunt and frame parsing
// Tracks sync, packet and reading position byte by byte, and registers one
// point record per completed reading of a good packet and per frame end.
// ----------------------------------------------------------------------------
module lsdc_deframer import lsdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [7:0]  in_byte,
   output logic        in_ready,
   output logic        pt_valid,
   output lsdc_pt_type pt,
   input  logic        pt_ready
);

   sync_type          sync_ff, sync_in;
   logic [5:0]        off_ff, off_in;
   logic [PKT_W-1:0]  pkt_ff, pkt_in;
   logic [8:0]        base_ff, base_in;
   logic [2:0]        ph_ff, ph_in;
   logic [2:0]        rd_ff, rd_in;
   logic              good_ff, good_in;
   logic [7:0]        speed_low_ff, speed_low_in;
   logic [12:0]       rpm_ff, rpm_in;
   logic [23:0]       rb_ff, rb_in;
   logic              pt_valid_ff, pt_valid_in;
   lsdc_pt_type       pt_ff, pt_in;

   logic        accept;
   logic        in_frame;
   logic        last_byte;
   logic        in_reading;
   logic        emit_rd;
   logic        emit_end;
   logic [31:0] rpm_prod;
   logic [8:0]  angle;

   assign in_ready   = !pt_valid_ff || pt_ready;
   assign accept     = in_valid && in_ready;
   assign in_frame   = (sync_ff == SYNC_FRAME);
   assign last_byte  = (pkt_ff == PKT_W'(PACKETS_PER_FRAME - 1)) && (off_ff == OFF_LAST);
   assign in_reading = (off_ff >= OFF_RD_FIRST) && (off_ff < OFF_RD_END);
   assign rpm_prod   = {in_byte, speed_low_ff} * RPM_RECIP;
   assign angle      = base_ff + 9'(rd_ff);

   // next state
   always_comb begin
      sync_in      = sync_ff;
      off_in       = off_ff;
      pkt_in       = pkt_ff;
      base_in      = base_ff;
      ph_in        = ph_ff;
      rd_in        = rd_ff;
      good_in      = good_ff;
      speed_low_in = speed_low_ff;
      rpm_in       = rpm_ff;
      rb_in        = rb_ff;
      if (accept) begin
         unique case (sync_ff)
            SYNC_HUNT: begin
               if (in_byte == SYNC_BYTE0) sync_in = SYNC_GOT_FA;
            end
            SYNC_GOT_FA: begin
               if (in_byte == SYNC_BYTE1) begin
                  sync_in = SYNC_FRAME;
                  off_in  = OFF_AFTER_SYNC;
                  pkt_in  = '0;
                  base_in = '0;
                  good_in = 1'b1;
               end else begin
                  sync_in = SYNC_HUNT;
               end
            end
            SYNC_FRAME: begin
               priority if (off_ff == OFF_HDR0) begin
                  good_in = (in_byte == SYNC_BYTE0);
               end else if (off_ff == OFF_HDR1) begin
                  good_in = good_ff && (in_byte == SYNC_BYTE1 + 8'(pkt_ff));
               end else if (off_ff == OFF_SPEED_LO) begin
                  speed_low_in = in_byte;
               end else if (off_ff == OFF_SPEED_HI) begin
                  if (good_ff) rpm_in = rpm_prod[RPM_SHIFT +: 13];
                  ph_in = '0;
                  rd_in = '0;
               end else if (in_reading) begin
                  unique case (ph_ff)
                     PH_INT_LO:   rb_in[7:0]   = in_byte;
                     PH_INT_HI:   rb_in[15:8]  = in_byte;
                     PH_RANGE_LO: rb_in[23:16] = in_byte;
                     default:     rb_in        = rb_ff;
                  endcase
                  if (ph_ff == PH_LAST) begin
                     ph_in = '0;
                     rd_in = (rd_ff == RD_LAST) ? '0 : rd_ff + 3'd1;
                  end else begin
                     ph_in = ph_ff + 3'd1;
                  end
               end else begin
                  rb_in = rb_ff;
               end
               // advance position
               if (last_byte) begin
                  sync_in = SYNC_HUNT;
                  off_in  = '0;
               end else if (off_ff == OFF_LAST) begin
                  off_in  = '0;
                  pkt_in  = pkt_ff + PKT_W'(1);
                  base_in = base_ff + ANGLE_STEP;
               end else begin
                  off_in = off_ff + 6'd1;
               end
            end
            default: sync_in = SYNC_HUNT;
         endcase
      end
   end

   // emitted record
   always_comb begin
      emit_rd  = accept && in_frame && in_reading && (ph_ff == PH_RANGE_HI) && good_ff;
      emit_end = accept && in_frame && last_byte;

      pt_in            = pt_ff;
      pt_in.frame_done = emit_end;
      pt_in.angle      = angle;
      pt_in.range_mm   = {in_byte, rb_ff[23:16]};
      pt_in.intensity  = rb_ff[15:0];
      pt_in.rpm        = rpm_ff;
      priority if (angle <= 9'd90) begin
         pt_in.dx_idx = 7'(angle);
         pt_in.dy_idx = 7'(9'd90 - angle);
         pt_in.x_neg  = 1'b0;
         pt_in.y_neg  = 1'b1;
      end else if (angle <= 9'd180) begin
         pt_in.dx_idx = 7'(9'd180 - angle);
         pt_in.dy_idx = 7'(angle - 9'd90);
         pt_in.x_neg  = 1'b0;
         pt_in.y_neg  = 1'b0;
      end else if (angle <= 9'd270) begin
         pt_in.dx_idx = 7'(angle - 9'd180);
         pt_in.dy_idx = 7'(9'd270 - angle);
         pt_in.x_neg  = 1'b1;
         pt_in.y_neg  = 1'b0;
      end else begin
         pt_in.dx_idx = 7'(9'd360 - angle);
         pt_in.dy_idx = 7'(angle - 9'd270);
         pt_in.x_neg  = 1'b1;
         pt_in.y_neg  = 1'b1;
      end

      if (emit_rd || emit_end) pt_valid_in = 1'b1;
      else if (pt_ready)       pt_valid_in = 1'b0;
      else                     pt_valid_in = pt_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff      <= SYNC_HUNT;
         off_ff       <= '0;
         pkt_ff       <= '0;
         base_ff      <= '0;
         ph_ff        <= '0;
         rd_ff        <= '0;
         good_ff      <= 1'b0;
         speed_low_ff <= '0;
         rpm_ff       <= '0;
         rb_ff        <= '0;
         pt_valid_ff  <= 1'b0;
      end else begin
         sync_ff      <= sync_in;
         off_ff       <= off_in;
         pkt_ff       <= pkt_in;
         base_ff      <= base_in;
         ph_ff        <= ph_in;
         rd_ff        <= rd_in;
         good_ff      <= good_in;
         speed_low_ff <= speed_low_in;
         rpm_ff       <= rpm_in;
         rb_ff        <= rb_in;
         pt_valid_ff  <= pt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_rd || emit_end) pt_ff <= pt_in;
   end

   assign pt_valid = pt_valid_ff;
   assign pt       = pt_ff;

endmodule

/* rtl/lsdc_xy.sv */
// ----------------------------------------------------------------------------
// lsdc_xy: polar to map coordinate stages
// Stage one looks up the folded sine table and scales by range; stage two
// offsets from the centre, checks the point and holds the result beat.
// ----------------------------------------------------------------------------
module lsdc_xy import lsdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        pt_valid,
   input  lsdc_pt_type pt,
   output logic        pt_ready,
   input  logic [14:0] center_x,
   input  logic [14:0] center_y,
   lsdc_rsp_if.source  rsp
);

   logic               vb_ff, vb_in;
   lsdc_pt_type        pb_ff;
   logic [15:0]        dx_ff, dy_ff;
   logic               vc_ff, vc_in;
   logic               ready_b, ready_c;

   logic [QW+15:0]     prod_x, prod_y;
   logic signed [17:0] x_full, y_full;
   logic               ok;

   logic               pv_ff;
   logic               fd_ff;
   logic [8:0]         ang_ff;
   logic [15:0]        rng_ff, int_ff;
   logic [16:0]        x_ff, y_ff;
   logic [12:0]        rpm_ff;

   assign ready_c  = !vc_ff || rsp.ready;
   assign ready_b  = !vb_ff || ready_c;
   assign pt_ready = ready_b;

   assign prod_x = pt.range_mm * QTAB[pt.dx_idx];
   assign prod_y = pt.range_mm * QTAB[pt.dy_idx];

   always_comb begin
      vb_in = ready_b ? pt_valid : vb_ff;
      vc_in = ready_c ? vb_ff : vc_ff;
   end

   always_comb begin
      x_full = pb_ff.x_neg ? ($signed({3'b000, center_x}) - $signed({2'b00, dx_ff}))
                           : ($signed({3'b000, center_x}) + $signed({2'b00, dx_ff}));
      y_full = pb_ff.y_neg ? ($signed({3'b000, center_y}) - $signed({2'b00, dy_ff}))
                           : ($signed({3'b000, center_y}) + $signed({2'b00, dy_ff}));
      ok = !pb_ff.frame_done && !(x_full == 18'sd0 && y_full == 18'sd0)
           && !x_full[17] && !y_full[17];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         vb_ff <= vb_in;
         vc_ff <= vc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_b && pt_valid) begin
         pb_ff <= pt;
         dx_ff <= prod_x[COS_FRAC_BITS +: 16];
         dy_ff <= prod_y[COS_FRAC_BITS +: 16];
      end
      if (ready_c && vb_ff) begin
         pv_ff  <= ok;
         fd_ff  <= pb_ff.frame_done;
         ang_ff <= pb_ff.frame_done ? '0 : pb_ff.angle;
         rng_ff <= pb_ff.frame_done ? '0 : pb_ff.range_mm;
         int_ff <= pb_ff.frame_done ? '0 : pb_ff.intensity;
         x_ff   <= ok ? x_full[16:0] : '0;
         y_ff   <= ok ? y_full[16:0] : '0;
         rpm_ff <= pb_ff.rpm;
      end
   end

   assign rsp.valid       = vc_ff;
   assign rsp.point_valid = pv_ff;
   assign rsp.frame_done  = fd_ff;
   assign rsp.angle_index = ang_ff;
   assign rsp.range_mm    = rng_ff;
   assign rsp.intensity   = int_ff;
   assign rsp.x_pos       = x_ff;
   assign rsp.y_pos       = y_ff;
   assign rsp.rpm         = rpm_ff;

endmodule

/* rtl/lidar_scan_deframer_cartesian_top.sv */
// ----------------------------------------------------------------------------
// lidar_scan_deframer_cartesian_top: lidar frame deframer with map output
// Accepts one byte per cycle unless the point path stalls it. A result for
// the byte that completes a reading or the frame passes the three-register
// point path (parse, scale, offset); one result beat per cycle at most.
// Synchronous active-high reset returns to sync hunt, centre to 5000/5000.
// ----------------------------------------------------------------------------
module lidar_scan_deframer_cartesian_top import lsdc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   lsdc_req_if.sink             req_bus,
   lsdc_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [14:0]          csr_wdata
);

   logic [14:0] center_x_ff, center_x_in;
   logic [14:0] center_y_ff, center_y_in;

   logic        pt_valid;
   logic        pt_ready;
   lsdc_pt_type pt;

   // register writes; other indexes drop
   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      if (csr_we) begin
         if (csr_index == CSR_CENTER_X) center_x_in = csr_wdata;
         if (csr_index == CSR_CENTER_Y) center_y_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= CENTER_RESET;
         center_y_ff <= CENTER_RESET;
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
      end
   end

   lsdc_deframer u_deframer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_byte  (req_bus.rx_byte),
      .in_ready (req_bus.ready),
      .pt_valid (pt_valid),
      .pt       (pt),
      .pt_ready (pt_ready)
   );

   lsdc_xy u_xy (
      .clock    (clock),
      .reset    (reset),
      .pt_valid (pt_valid),
      .pt       (pt),
      .pt_ready (pt_ready),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .rsp      (rsp_bus)
   );

endmodule

/* test/tb_lidar_scan_deframer_cartesian_top.sv */
// ----------------------------------------------------------------------------
// tb_lidar_scan_deframer_cartesian_top: self-checking bench for the deframer
// Streams serial bytes (line noise, broken sync pairs, then the opening
// packets of a frame with good and corrupted packet headers) into the byte
// channel. Every accepted beat feeds a local frame tracker that predicts the
// map points. Those predictions are checked in order against the point
// channel, under random source gaps and sink stalls, across several center
// settings.
// ----------------------------------------------------------------------------
module tb_lidar_scan_deframer_cartesian_top;
   import lsdc_pkg::*;

   localparam int PACKET_BYTES  = 42;
   localparam int FRAME_BYTES   = PACKETS_PER_FRAME * PACKET_BYTES;
   localparam int READING_BYTES = 6;
   localparam int RPM_DIVISOR   = 10;
   localparam int POINT_LATENCY = 3;
   localparam int DRAIN_CYCLES  = 4 * POINT_LATENCY + 4;
   localparam int MAX_REPORTS   = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam longint unsigned SINE_SCALE = 64'd10000000000;

   typedef struct packed {
      logic        point_valid;
      logic        frame_done;
      logic [8:0]  angle_index;
      logic [15:0] range_mm;
      logic [15:0] intensity;
      logic [16:0] x_pos;
      logic [16:0] y_pos;
      logic [12:0] rpm;
   } scan_point_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [14:0]          csr_wdata = '0;

   lsdc_req_if req_if();
   lsdc_rsp_if rsp_if();

   lidar_scan_deframer_cartesian_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // sin(d degrees) to ten decimals, times 1e10
   longint unsigned sine_e10 [0:90] = '{
      64'd0,          64'd174524064,  64'd348994967,  64'd523359562,  64'd697564737,
      64'd871557427,  64'd1045284633, 64'd1218693434, 64'd1391731010, 64'd1564344650,
      64'd1736481777, 64'd1908089954, 64'd2079116908, 64'd2249510543, 64'd2419218956,
      64'd2588190451, 64'd2756373558, 64'd2923717047, 64'd3090169944, 64'd3255681545,
      64'd3420201433, 64'd3583679495, 64'd3746065934, 64'd3907311285, 64'd4067366431,
      64'd4226182617, 64'd4383711468, 64'd4539904997, 64'd4694715628, 64'd4848096202,
      64'd5000000000, 64'd5150380749, 64'd5299192642, 64'd5446390350, 64'd5591929035,
      64'd5735764364, 64'd5877852523, 64'd6018150232, 64'd6156614753, 64'd6293203910,
      64'd6427876097, 64'd6560590290, 64'd6691306064, 64'd6819983601, 64'd6946583705,
      64'd7071067812, 64'd7193398003, 64'd7313537016, 64'd7431448255, 64'd7547095802,
      64'd7660444431, 64'd7771459615, 64'd7880107536, 64'd7986355100, 64'd8090169944,
      64'd8191520443, 64'd8290375726, 64'd8386705679, 64'd8480480962, 64'd8571673007,
      64'd8660254038, 64'd8746197071, 64'd8829475929, 64'd8910065242, 64'd8987940463,
      64'd9063077870, 64'd9135454576, 64'd9205048535, 64'd9271838546, 64'd9335804265,
      64'd9396926208, 64'd9455185756, 64'd9510565163, 64'd9563047560, 64'd9612616959,
      64'd9659258263, 64'd9702957263, 64'd9743700648, 64'd9781476007, 64'd9816271834,
      64'd9848077530, 64'd9876883406, 64'd9902680687, 64'd9925461516, 64'd9945218954,
      64'd9961946981, 64'd9975640503, 64'd9986295348, 64'd9993908270, 64'd9998476952,
      64'd10000000000
   };

   // frame tracker state and its copy of the center registers
   sync_type    sync_state;
   int          frame_pos;
   logic        pkt_ok;
   logic [7:0]  speed_lo;
   logic [12:0] rpm_now;
   logic [23:0] reading;
   logic [14:0] ctr_x;
   logic [14:0] ctr_y;

   scan_point_type points_due[$];
   logic [7:0]     byte_q[$];
   bit             calm = 1'b0;
   int             gap_left = 0;
   int             stall_left = 0;
   int             errors = 0;
   int             bytes_in = 0;
   int             points_seen = 0;
   int             rejects_seen = 0;
   int             ends_seen = 0;

   function automatic longint unsigned quarter_scale(int d);
      return (sine_e10[d] << COS_FRAC_BITS) / SINE_SCALE;
   endfunction

   function automatic longint map_offset(logic [15:0] rng, int d);
      return longint'((64'(rng) * quarter_scale(d)) >> COS_FRAC_BITS);
   endfunction

   function automatic scan_point_type place_point(int ang, logic [15:0] inten,
                                                  logic [15:0] rng);
      longint         cx;
      longint         cy;
      longint         x;
      longint         y;
      scan_point_type p;
      cx = ctr_x;
      cy = ctr_y;
      if (ang <= 90) begin
         x = cx + map_offset(rng, ang);
         y = cy - map_offset(rng, 90 - ang);
      end else if (ang <= 180) begin
         x = cx + map_offset(rng, 180 - ang);
         y = cy + map_offset(rng, ang - 90);
      end else if (ang <= 270) begin
         x = cx - map_offset(rng, ang - 180);
         y = cy + map_offset(rng, 270 - ang);
      end else begin
         x = cx - map_offset(rng, 360 - ang);
         y = cy - map_offset(rng, ang - 270);
      end
      p             = '0;
      p.point_valid = !(x == 0 && y == 0) && x >= 0 && y >= 0;
      p.angle_index = 9'(ang);
      p.range_mm    = rng;
      p.intensity   = inten;
      p.rpm         = rpm_now;
      if (p.point_valid) begin
         p.x_pos = 17'(x);
         p.y_pos = 17'(y);
      end
      return p;
   endfunction

   // advance the frame tracker by one accepted byte
   function automatic void deframe_byte(logic [7:0] b);
      int             pkt;
      int             off;
      int             rd;
      int             ph;
      bit             emit;
      scan_point_type p;
      emit = 1'b0;
      p    = '0;
      unique case (sync_state)
         SYNC_HUNT: begin
            if (b == SYNC_BYTE0) sync_state = SYNC_GOT_FA;
         end
         SYNC_GOT_FA: begin
            if (b == SYNC_BYTE1) begin
               sync_state = SYNC_FRAME;
               frame_pos  = int'(OFF_AFTER_SYNC);
               pkt_ok     = 1'b1;
            end else begin
               sync_state = SYNC_HUNT;
            end
         end
         default: begin
            pkt = frame_pos / PACKET_BYTES;
            off = frame_pos % PACKET_BYTES;
            if (off == OFF_HDR0) begin
               pkt_ok = (b == SYNC_BYTE0);
            end else if (off == OFF_HDR1) begin
               pkt_ok = pkt_ok && (b == 8'(SYNC_BYTE1 + pkt));
            end else if (off == OFF_SPEED_LO) begin
               speed_lo = b;
            end else if (off == OFF_SPEED_HI) begin
               if (pkt_ok) rpm_now = 13'({b, speed_lo} / RPM_DIVISOR);
            end else if (off >= OFF_RD_FIRST && off < OFF_RD_END) begin
               rd = (off - OFF_RD_FIRST) / READING_BYTES;
               ph = (off - OFF_RD_FIRST) % READING_BYTES;
               if (ph < PH_RANGE_HI) begin
                  reading[8*ph +: 8] = b;
               end else if (ph == PH_RANGE_HI && pkt_ok) begin
                  p = place_point(int'(ANGLE_STEP) * pkt + rd, reading[15:0],
                                  {b, reading[23:16]});
                  emit = 1'b1;
               end
            end
            if (frame_pos + 1 >= FRAME_BYTES) begin
               sync_state   = SYNC_HUNT;
               frame_pos    = 0;
               p            = '0;
               p.frame_done = 1'b1;
               p.rpm        = rpm_now;
               emit         = 1'b1;
            end else begin
               frame_pos = frame_pos + 1;
            end
         end
      endcase
      if (emit) points_due.push_back(p);
   endfunction

   // extremes, tiny values, values near a center coordinate, or anything
   function automatic logic [15:0] pick_word(int near);
      unique case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 15));
         3: return 16'(near + int'($urandom_range(0, 6)) - 3);
         default: return 16'($urandom);
      endcase
   endfunction

   // line noise that never completes a sync pair
   task automatic queue_noise(int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom);
         if ($urandom_range(0, 5) == 0) begin
            byte_q.push_back(SYNC_BYTE0);
            if (b == SYNC_BYTE1) b = b ^ 8'h01;
         end else if (b == SYNC_BYTE0) begin
            b = ~b;
         end
         byte_q.push_back(b);
      end
   endtask

   // frame bytes from position first up to last; at position zero the sync
   // pair stands in for the first header; bad_pct spoils packet headers
   task automatic queue_frame(int bad_pct, int first, int last);
      int          pkt;
      int          off;
      int          ph;
      logic [15:0] w;
      w = '0;
      if (first == 0) begin
         byte_q.push_back(SYNC_BYTE0);
         byte_q.push_back(SYNC_BYTE1);
      end
      for (int pos = (first == 0) ? int'(OFF_AFTER_SYNC) : first; pos < last; pos++) begin
         pkt = pos / PACKET_BYTES;
         off = pos % PACKET_BYTES;
         if (off == OFF_HDR0) begin
            byte_q.push_back(($urandom_range(1, 100) <= bad_pct) ? 8'($urandom)
                                                                 : SYNC_BYTE0);
         end else if (off == OFF_HDR1) begin
            byte_q.push_back(($urandom_range(1, 100) <= bad_pct) ? 8'($urandom)
                                                                 : 8'(SYNC_BYTE1 + pkt));
         end else if (off == OFF_SPEED_LO) begin
            w = pick_word(0);
            byte_q.push_back(w[7:0]);
         end else if (off == OFF_SPEED_HI) begin
            byte_q.push_back(w[15:8]);
         end else if (off >= OFF_RD_FIRST && off < OFF_RD_END) begin
            ph = (off - OFF_RD_FIRST) % READING_BYTES;
            if (ph == PH_INT_LO || ph == PH_RANGE_LO) begin
               w = pick_word($urandom_range(0, 1) ? int'(ctr_x) : int'(ctr_y));
               byte_q.push_back(w[7:0]);
            end else if (ph == PH_INT_HI || ph == PH_RANGE_HI) begin
               byte_q.push_back(w[15:8]);
            end else begin
               byte_q.push_back(8'($urandom));
            end
         end else begin
            byte_q.push_back(8'($urandom));
         end
      end
   endtask

   // hold until every byte is taken and every point is back, then drain
   task automatic settle();
      do @(negedge clock);
      while (byte_q.size() != 0 || req_if.valid || points_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [14:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_CENTER_X) ctr_x = val;
      else if (idx == CSR_CENTER_Y) ctr_y = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_center(logic [14:0] x, logic [14:0] y);
      write_csr(CSR_CENTER_X, x);
      write_csr(CSR_CENTER_Y, y);
      @(negedge clock);
   endtask

   always @(posedge clock) begin : byte_drv
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            bytes_in++;
            deframe_byte(req_if.rx_byte);
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
               gap_left = $urandom_range(0, 8);
               req_if.valid <= 1'b0;
            end else if (byte_q.size() != 0) begin
               req_if.valid   <= 1'b1;
               req_if.rx_byte <= byte_q.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : point_mon
      scan_point_type got;
      scan_point_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.point_valid = rsp_if.point_valid;
            got.frame_done  = rsp_if.frame_done;
            got.angle_index = rsp_if.angle_index;
            got.range_mm    = rsp_if.range_mm;
            got.intensity   = rsp_if.intensity;
            got.x_pos       = rsp_if.x_pos;
            got.y_pos       = rsp_if.y_pos;
            got.rpm         = rsp_if.rpm;
            if (got.frame_done) ends_seen++;
            else if (got.point_valid) points_seen++;
            else rejects_seen++;
            if (points_due.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: point beat with nothing pending: %p", $realtime, got);
            end else begin
               want = points_due.pop_front();
               if (got.point_valid !== want.point_valid || got.frame_done !== want.frame_done
                   || got.angle_index !== want.angle_index
                   || got.range_mm !== want.range_mm || got.intensity !== want.intensity
                   || got.x_pos !== want.x_pos || got.y_pos !== want.y_pos
                   || got.rpm !== want.rpm) begin
                  errors++;
                  if (errors <= MAX_REPORTS) begin
                     $display("%0t: point mismatch", $realtime);
                     $display("   expected %p", want);
                     $display("   actual   %p", got);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready   = 1'b0;
      sync_state     = SYNC_HUNT;
      frame_pos      = 0;
      pkt_ok         = 1'b0;
      speed_lo       = '0;
      rpm_now        = '0;
      reading        = '0;
      ctr_x          = CENTER_RESET;
      ctr_y          = CENTER_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sync hunting: stray second byte, bad second byte, repeated first byte
      byte_q.push_back(8'h00);
      byte_q.push_back(8'hFF);
      byte_q.push_back(SYNC_BYTE1);
      byte_q.push_back(SYNC_BYTE0);
      byte_q.push_back(8'h55);
      byte_q.push_back(SYNC_BYTE1);
      byte_q.push_back(SYNC_BYTE0);
      byte_q.push_back(SYNC_BYTE0);
      byte_q.push_back(SYNC_BYTE1);
      byte_q.push_back(SYNC_BYTE0);
      byte_q.push_back(8'hA1);
      byte_q.push_back(8'h7F);
      byte_q.push_back(8'h80);
      queue_noise(8);
      queue_frame(10, 0, 210);
      settle();

      // spare indexes must not disturb the center
      write_csr(CSR_SPARE_A, 15'($urandom));
      write_csr(CSR_SPARE_B, 15'h7FFF);
      write_center(15'd0, 15'd0);
      queue_frame(0, 210, 336);
      settle();

      write_center(15'h7FFF, 15'h7FFF);
      queue_frame(5, 336, 462);
      settle();

      write_center(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)));
      queue_frame(50, 462, 588);
      settle();

      calm = 1'b1;
      write_center(15'($urandom_range(0, 200)), 15'($urandom_range(32000, 32767)));
      queue_frame(10, 588, 756);
      settle();

      $display("ran %0d bytes: sync hunting, then the first 18 packets of a frame",
               bytes_in);
      $display("%0d kept points, %0d rejected points, %0d frame ends; %0d mismatches",
               points_seen, rejects_seen, ends_seen, errors);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("timeout with %0d bytes queued and %0d points pending",
               byte_q.size(), points_due.size());
      $display("status: fail");
      $finish;
   end

endmodule
